// ----- hdl/srr_pkg.sv -----
package srr_pkg;

	// Default sizes of the receive window, sequence space and payload store.
	localparam int WINDOW_SIZE_DEF  = 4;
	localparam int SEQ_SPACE_DEF    = 8;
	localparam int PAYLOAD_BITS_DEF = 64;

	// Fixed field widths of the packet and result items.
	localparam int SEQ_W     = 3;
	localparam int PAYLOAD_W = 64;

	// Result kind codes.
	localparam logic KIND_DELIVER = 1'b0;
	localparam logic KIND_ACK     = 1'b1;

	// One arriving packet.
	typedef struct packed {
		logic [SEQ_W-1:0]     seq_number;
		logic                 checksum_good;
		logic [PAYLOAD_W-1:0] payload;
	} pkt_t;

	// One result: an in-order delivery or the closing acknowledgement.
	typedef struct packed {
		logic                 result_kind;
		logic [PAYLOAD_W-1:0] delivered_payload;
		logic [SEQ_W-1:0]     ack_number;
		logic                 last;
	} res_t;

endpackage

// ----- hdl/selective_repeat_receiver.sv -----
// Selective-repeat receiver with cumulative acknowledgement. A packet is taken
// when start is high and busy is low; the block then stays busy until its last
// result has been issued. Results appear on res for one cycle each, marked by
// res_valid, and the receiver cannot stall them: zero or more in-order
// deliveries (result_kind 0) followed by one acknowledgement (result_kind 1,
// last 1). Every result of a packet carries the window base after that packet.
// A corrupt or out-of-window packet goes straight to the acknowledgement.
// A buffered packet that releases n payloads is first stored; then the scan
// pointer walks the filled flags to find the new base, the base pointer reads
// one payload per cycle from the single read port of the slot store, and at
// last the acknowledgement is issued. The acknowledgement is on the ports in
// the cycle in which busy falls, so the next packet can be taken at the edge
// that ends it.
module selective_repeat_receiver
	import srr_pkg::*;
#(
	parameter int WINDOW_SIZE  = WINDOW_SIZE_DEF,
	parameter int SEQ_SPACE    = SEQ_SPACE_DEF,
	parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  pkt_t pkt,
	output logic res_valid,
	output res_t res
);

	// Widths derived from the parameters.
	localparam int BW = (SEQ_SPACE > 2) ? $clog2(SEQ_SPACE) : 1;
	localparam int SW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
	localparam int NW = $clog2(WINDOW_SIZE + 1);
	localparam int CW = ((BW > SEQ_W) ? BW : SEQ_W) + 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DELIVER,
		ST_ACK
	} state_t;

	state_t                  state_q;
	logic [BW-1:0]           base_q;
	logic [SW-1:0]           base_slot_q;
	logic [BW-1:0]           scan_base_q;
	logic [SW-1:0]           scan_slot_q;
	logic [NW-1:0]           cnt_q;
	logic [WINDOW_SIZE-1:0]  filled_q;
	logic                    valid_q;
	logic                    kind_q;
	logic [SEQ_W-1:0]        ack_q;
	logic                    last_q;
	logic [PAYLOAD_BITS-1:0] rd_q;
	logic [PAYLOAD_BITS-1:0] mem_q [WINDOW_SIZE];

	logic                    accept;
	logic [SW-1:0]           slot_lut [1 << SEQ_W];
	logic [SW-1:0]           wr_slot;
	logic [CW-1:0]           seq_w;
	logic [CW-1:0]           diff;
	logic [CW-1:0]           gap;
	logic                    seq_ok;
	logic                    in_window;
	logic                    store;
	logic [BW-1:0]           base_inc;
	logic [SW-1:0]           slot_inc;
	logic [BW-1:0]           scan_base_inc;
	logic [SW-1:0]           scan_slot_inc;
	logic [CW-1:0]           base_ext;
	logic [CW-1:0]           scan_ext;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	// Slot of each possible sequence number, fixed at elaboration.
	for (genvar g = 0; g < (1 << SEQ_W); g++) begin : g_slot
		localparam int SLOT = g % WINDOW_SIZE;
		assign slot_lut[g] = SW'(SLOT);
	end

	// Window test: distance from the base modulo the sequence space.
	assign seq_w   = CW'(pkt.seq_number);
	assign seq_ok  = (seq_w < CW'(SEQ_SPACE));
	assign diff    = seq_w - CW'(base_q);
	assign gap     = diff[CW-1] ? (diff + CW'(SEQ_SPACE)) : diff;
	assign in_window = seq_ok && ((WINDOW_SIZE >= SEQ_SPACE) || (32'(gap) < WINDOW_SIZE));
	assign store   = accept && pkt.checksum_good && in_window;
	assign wr_slot = slot_lut[pkt.seq_number];

	// Shared pointer step: the base and its slot wrap together.
	always_comb begin
		base_inc      = (base_q == BW'(SEQ_SPACE - 1)) ? '0 : base_q + 1'b1;
		slot_inc      = ((base_q == BW'(SEQ_SPACE - 1)) ||
		                 (base_slot_q == SW'(WINDOW_SIZE - 1))) ? '0 : base_slot_q + 1'b1;
		scan_base_inc = (scan_base_q == BW'(SEQ_SPACE - 1)) ? '0 : scan_base_q + 1'b1;
		scan_slot_inc = ((scan_base_q == BW'(SEQ_SPACE - 1)) ||
		                 (scan_slot_q == SW'(WINDOW_SIZE - 1))) ? '0 : scan_slot_q + 1'b1;
	end

	assign base_ext = CW'(base_q);
	assign scan_ext = CW'(scan_base_q);

	// Slot store: written on a buffered packet, read once per delivery.
	always_ff @(posedge clk) begin
		if (store) begin
			mem_q[wr_slot] <= pkt.payload[PAYLOAD_BITS-1:0];
		end
		if (state_q == ST_DELIVER) begin
			rd_q <= mem_q[base_slot_q];
		end
	end

	// Sequencer with the filled flags, the window base and the result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			base_q      <= '0;
			base_slot_q <= '0;
			scan_base_q <= '0;
			scan_slot_q <= '0;
			cnt_q       <= '0;
			filled_q    <= '0;
			valid_q     <= 1'b0;
			kind_q      <= KIND_ACK;
			ack_q       <= '0;
			last_q      <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						scan_base_q <= base_q;
						scan_slot_q <= base_slot_q;
						cnt_q       <= '0;
						if (store) begin
							filled_q[wr_slot] <= 1'b1;
							state_q           <= ST_SCAN;
						end else begin
							state_q <= ST_ACK;
						end
					end
				end
				ST_SCAN: begin
					// Walk the consecutive filled slots to find the new base.
					if (filled_q[scan_slot_q] && (32'(cnt_q) < WINDOW_SIZE)) begin
						scan_base_q <= scan_base_inc;
						scan_slot_q <= scan_slot_inc;
						cnt_q       <= cnt_q + 1'b1;
					end else if (cnt_q == '0) begin
						state_q <= ST_ACK;
					end else begin
						state_q <= ST_DELIVER;
					end
				end
				ST_DELIVER: begin
					// One payload per cycle; every result carries the final base.
					valid_q               <= 1'b1;
					kind_q                <= KIND_DELIVER;
					ack_q                 <= scan_ext[SEQ_W-1:0];
					last_q                <= 1'b0;
					filled_q[base_slot_q] <= 1'b0;
					base_q                <= base_inc;
					base_slot_q           <= slot_inc;
					cnt_q                 <= cnt_q - 1'b1;
					if (cnt_q == NW'(1)) begin
						state_q <= ST_ACK;
					end
				end
				ST_ACK: begin
					valid_q <= 1'b1;
					kind_q  <= KIND_ACK;
					ack_q   <= base_ext[SEQ_W-1:0];
					last_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result fields; acknowledgements carry a zero payload.
	assign res_valid             = valid_q;
	assign res.result_kind       = kind_q;
	assign res.delivered_payload = (kind_q == KIND_ACK) ? '0 : PAYLOAD_W'(rd_q);
	assign res.ack_number        = ack_q;
	assign res.last              = last_q;

endmodule
